// File: rtl/pvenv_pkg.sv
package pvenv_pkg;

	// voice constants
	localparam int PHASE_BITS   = 18;
	localparam int AUDIO_RATE   = 30000;
	localparam int OCTAVE_SHIFT = 0;
	localparam int MULT_BITS    = 4;
	localparam logic [MULT_BITS-1:0] CARRIER_MULT = 4'd2;

	localparam int LEVEL_BITS  = 12;
	localparam int SHIFT_BITS  = 4;
	localparam int DEPTH_BITS  = 8;
	localparam int VIB_BITS    = 12;
	localparam int SAMPLE_BITS = 14;
	localparam int NOTE_BITS   = 7;
	localparam int NOTE_COUNT  = 128;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	localparam logic [LEVEL_BITS-1:0] LEVEL_FULL = 12'd4095;
	localparam logic signed [VIB_BITS-1:0] COS_START = 12'sd1023;

	// command codes
	typedef enum logic [1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_ENV_TICK = 2'd2,
		OP_SAMPLE   = 2'd3
	} op_t;

	// register map, word index
	typedef enum logic [2:0] {
		REG_SUSTAIN   = 3'd0,
		REG_DECAY     = 3'd1,
		REG_RELEASE   = 3'd2,
		REG_VIB_SPEED = 3'd3,
		REG_VIB_ATTK  = 3'd4,
		REG_VIB_DEPTH = 3'd5,
		REG_DUTY      = 3'd6,
		REG_DETUNE    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] sustain_level;
		logic [SHIFT_BITS-1:0] decay_shift;
		logic [SHIFT_BITS-1:0] release_shift;
		logic [SHIFT_BITS-1:0] vib_speed_shift;
		logic [SHIFT_BITS-1:0] vib_attack_shift;
		logic [DEPTH_BITS-1:0] vib_depth_max;
		logic                  duty_select;
		logic [PHASE_BITS-1:0] second_detune;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sustain_level:    12'd2048,
		decay_shift:      4'd4,
		release_shift:    4'd4,
		vib_speed_shift:  4'd6,
		vib_attack_shift: 4'd0,
		vib_depth_max:    8'd0,
		duty_select:      1'b0,
		second_detune:    18'd0
	};

	// top -> envelope
	typedef struct packed {
		logic                 note_on;
		logic                 note_off;
		logic                 tick;
		logic [NOTE_BITS-1:0] note;
	} env_cmd_t;

	// envelope -> oscillator
	typedef struct packed {
		logic [LEVEL_BITS-1:0]       level;
		logic [PHASE_BITS-1:0]       pitch;
		logic [DEPTH_BITS-1:0]       depth;
		logic signed [VIB_BITS-1:0]  cosine;
	} voice_t;

	// top <-> oscillator
	typedef struct packed {
		logic clear;
		logic start;
	} osc_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} osc_stat_t;

	// pitch step table, built at elaboration
	typedef logic [24:0] frac_t;
	localparam frac_t SEMI_FRAC [12] = '{
		25'd16777216, 25'd17774841, 25'd18831788, 25'd19951585,
		25'd21137968, 25'd22394897, 25'd23726566, 25'd25137421,
		25'd26632170, 25'd28215802, 25'd29893600, 25'd31671166
	};
	localparam longint unsigned STEP_DEN = longint'(AUDIO_RATE) << 24;

	typedef logic [NOTE_COUNT-1:0][PHASE_BITS-1:0] step_tab_t;

	function automatic step_tab_t build_steps();
		step_tab_t tab;
		int ee;
		int q;
		int r;
		int s;
		longint unsigned num;
		tab = '0;
		for (int n = 0; n < NOTE_COUNT; n++) begin
			ee = n - 69 + 12 * OCTAVE_SHIFT + 12 * 16;
			if (ee < 0) ee = 0;
			q = ee / 12 - 16;
			r = ee % 12;
			num = 64'd440 * longint'(SEMI_FRAC[r]);
			s = PHASE_BITS + q;
			if (s >= 0) begin
				if (s > 29) s = 29;
				num = num << s;
			end else begin
				if (s < -20) s = -20;
				num = num >> (-s);
			end
			tab[n] = PHASE_BITS'(num / STEP_DEN);
		end
		return tab;
	endfunction

	localparam step_tab_t STEP_TABLE = build_steps();

endpackage

// File: rtl/pvenv_cmd_if.sv
interface pvenv_cmd_if;
	logic                            valid;
	logic                            ready;
	pvenv_pkg::op_t                  opcode;
	logic [pvenv_pkg::NOTE_BITS-1:0] note;

	modport source (output valid, output opcode, output note, input ready);
	modport sink   (input valid, input opcode, input note, output ready);
endinterface

// File: rtl/pvenv_smp_if.sv
interface pvenv_smp_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pvenv_pkg::SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/pvenv_regs.sv
module pvenv_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pvenv_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pvenv_pkg::DATA_BITS-1:0] pwdata,
	output logic [pvenv_pkg::DATA_BITS-1:0] prdata,
	output logic                            pready,
	output pvenv_pkg::cfg_t                 cfg
);

	pvenv_pkg::cfg_t      cfg_q;
	pvenv_pkg::reg_idx_t  idx;
	logic                 wr;

	assign idx    = pvenv_pkg::reg_idx_t'(paddr[pvenv_pkg::ADDR_BITS-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pvenv_pkg::CFG_RESET;
		end else if (wr) begin
			unique case (idx)
				pvenv_pkg::REG_SUSTAIN:   cfg_q.sustain_level    <= pwdata[11:0];
				pvenv_pkg::REG_DECAY:     cfg_q.decay_shift      <= pwdata[3:0];
				pvenv_pkg::REG_RELEASE:   cfg_q.release_shift    <= pwdata[3:0];
				pvenv_pkg::REG_VIB_SPEED: cfg_q.vib_speed_shift  <= pwdata[3:0];
				pvenv_pkg::REG_VIB_ATTK:  cfg_q.vib_attack_shift <= pwdata[3:0];
				pvenv_pkg::REG_VIB_DEPTH: cfg_q.vib_depth_max    <= pwdata[7:0];
				pvenv_pkg::REG_DUTY:      cfg_q.duty_select      <= pwdata[0];
				pvenv_pkg::REG_DETUNE:    cfg_q.second_detune    <= pwdata[17:0];
				default:                  cfg_q                  <= cfg_q;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			pvenv_pkg::REG_SUSTAIN:   prdata = 32'(cfg_q.sustain_level);
			pvenv_pkg::REG_DECAY:     prdata = 32'(cfg_q.decay_shift);
			pvenv_pkg::REG_RELEASE:   prdata = 32'(cfg_q.release_shift);
			pvenv_pkg::REG_VIB_SPEED: prdata = 32'(cfg_q.vib_speed_shift);
			pvenv_pkg::REG_VIB_ATTK:  prdata = 32'(cfg_q.vib_attack_shift);
			pvenv_pkg::REG_VIB_DEPTH: prdata = 32'(cfg_q.vib_depth_max);
			pvenv_pkg::REG_DUTY:      prdata = 32'(cfg_q.duty_select);
			pvenv_pkg::REG_DETUNE:    prdata = 32'(cfg_q.second_detune);
			default:                  prdata = '0;
		endcase
	end

endmodule

// File: rtl/pvenv_env.sv
module pvenv_env (
	input  logic                clk,
	input  logic                arst_n,
	input  pvenv_pkg::cfg_t     cfg,
	input  pvenv_pkg::env_cmd_t cmd,
	output pvenv_pkg::voice_t   voice
);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

	stage_t                                   stage_q;
	logic [pvenv_pkg::LEVEL_BITS-1:0]         level_q;
	logic [pvenv_pkg::PHASE_BITS-1:0]         pitch_q;
	logic signed [pvenv_pkg::VIB_BITS-1:0]    sine_q;
	logic signed [pvenv_pkg::VIB_BITS-1:0]    cosine_q;
	logic [pvenv_pkg::DEPTH_BITS-1:0]         depth_q;

	logic signed [pvenv_pkg::VIB_BITS-1:0]    cos_rot;
	logic signed [pvenv_pkg::VIB_BITS-1:0]    sin_rot;
	logic [pvenv_pkg::LEVEL_BITS-1:0]         dec_lvl;
	logic [pvenv_pkg::LEVEL_BITS-1:0]         rel_lvl;
	logic [pvenv_pkg::DEPTH_BITS-1:0]         dep_up;
	logic [pvenv_pkg::DEPTH_BITS-1:0]         dep_dn;
	logic [pvenv_pkg::DEPTH_BITS-1:0]         depth_ramp;

	// right shift rounded up
	function automatic logic [11:0] ceil_shr(input logic [11:0] v, input logic [3:0] s);
		logic [11:0] mask;
		mask = ~(12'hFFF << s);
		return (v >> s) + 12'(|(v & mask));
	endfunction

	// vibrato rotation, new cosine feeds the sine
	assign cos_rot = cosine_q - (sine_q >>> cfg.vib_speed_shift);
	assign sin_rot = sine_q + (cos_rot >>> cfg.vib_speed_shift);

	// decay and release level steps
	assign dec_lvl = (level_q > cfg.sustain_level)
		? level_q - ceil_shr(level_q - cfg.sustain_level, cfg.decay_shift)
		: level_q;
	assign rel_lvl = level_q - ceil_shr(level_q, cfg.release_shift);

	// vibrato depth ramp toward its target
	assign dep_up = cfg.vib_depth_max - depth_q;
	assign dep_dn = depth_q - cfg.vib_depth_max;
	assign depth_ramp = (cfg.vib_depth_max >= depth_q)
		? depth_q + 8'(ceil_shr({4'b0, dep_up}, cfg.vib_attack_shift))
		: depth_q - (dep_dn >> cfg.vib_attack_shift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_IDLE;
			level_q  <= '0;
			pitch_q  <= '0;
			sine_q   <= '0;
			cosine_q <= '0;
			depth_q  <= '0;
		end else if (cmd.note_on) begin
			pitch_q  <= pvenv_pkg::STEP_TABLE[cmd.note];
			stage_q  <= ST_DECAY;
			level_q  <= pvenv_pkg::LEVEL_FULL;
			sine_q   <= '0;
			cosine_q <= pvenv_pkg::COS_START;
			depth_q  <= '0;
		end else if (cmd.note_off) begin
			stage_q <= ST_RELEASE;
		end else if (cmd.tick) begin
			cosine_q <= cos_rot;
			sine_q   <= sin_rot;
			unique case (stage_q)
				ST_IDLE: begin
				end
				ST_ATTACK: begin
					level_q <= pvenv_pkg::LEVEL_FULL;
					stage_q <= ST_DECAY;
				end
				ST_DECAY: begin
					if (dec_lvl <= cfg.sustain_level) begin
						level_q <= cfg.sustain_level;
						stage_q <= ST_SUSTAIN;
					end else begin
						level_q <= dec_lvl;
					end
					if (cfg.vib_attack_shift != '0) depth_q <= depth_ramp;
				end
				ST_SUSTAIN: begin
					level_q <= cfg.sustain_level;
				end
				ST_RELEASE: begin
					level_q <= rel_lvl;
					if (rel_lvl == '0) stage_q <= ST_IDLE;
				end
				default: begin
					// undefined stage codes only rotate the vibrato pair
				end
			endcase
		end
	end

	assign voice.level  = level_q;
	assign voice.pitch  = pitch_q;
	assign voice.depth  = depth_q;
	assign voice.cosine = cosine_q;

endmodule

// File: rtl/pvenv_osc.sv
module pvenv_osc (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  pvenv_pkg::cfg_t                          cfg,
	input  pvenv_pkg::voice_t                        voice,
	input  pvenv_pkg::osc_ctl_t                      ctl,
	output pvenv_pkg::osc_stat_t                     stat,
	output logic signed [pvenv_pkg::SAMPLE_BITS-1:0] sample
);

	localparam int PB        = pvenv_pkg::PHASE_BITS;
	localparam int ACC_BITS  = 20;
	localparam int VIB_SHIFT = 10;
	localparam int CNT_BITS  = $clog2(PB);
	localparam int MB        = pvenv_pkg::MULT_BITS;
	localparam logic CARRIER_BIT0 = pvenv_pkg::CARRIER_MULT[0];

	typedef enum logic [1:0] {
		OS_IDLE,
		OS_MUL,
		OS_ADD
	} ostate_t;

	ostate_t                                   state_q;
	logic [CNT_BITS-1:0]                       cnt_q;
	logic                                      done_q;
	logic [PB-1:0]                             main_q;
	logic [PB-1:0]                             second_q;
	logic [PB-1:0]                             pitch_sr_q;
	logic [PB-1:0]                             det_sr_q;
	logic [pvenv_pkg::DEPTH_BITS-1:0]          mplier_q;
	logic signed [ACC_BITS-1:0]                mcand_q;
	logic signed [ACC_BITS-1:0]                acc_q;
	logic                                      inc_c_q;
	logic                                      main_c_q;
	logic [2:0]                                sec_c_q;
	logic [MB-2:0]                             hist_q;
	logic signed [pvenv_pkg::SAMPLE_BITS-1:0]  sample_q;

	logic signed [ACC_BITS-1:0]                acc_mul;
	logic [1:0]                                inc_sum;
	logic [1:0]                                main_sum;
	logic [2:0]                                msum;
	logic [3:0]                                sec_sum;
	logic                                      main_hi;
	logic                                      second_hi;
	logic [pvenv_pkg::SAMPLE_BITS-1:0]         twice_lvl;
	logic [pvenv_pkg::SAMPLE_BITS-1:0]         sample_next;

	// wave outputs from the current phases
	assign main_hi   = main_q[PB-1] & (main_q[PB-2] | ~cfg.duty_select);
	assign second_hi = second_q[PB-1] & (second_q[PB-2] | ~cfg.duty_select);
	assign twice_lvl = {1'b0, voice.level, 1'b0};
	always_comb begin
		if (main_hi && second_hi)        sample_next = twice_lvl;
		else if (!main_hi && !second_hi) sample_next = -twice_lvl;
		else                             sample_next = '0;
	end

	// shift-add step of depth * cosine
	assign acc_mul = acc_q + (mplier_q[0] ? mcand_q : '0);

	// bit-serial adders, LSB first
	assign inc_sum  = 2'(pitch_sr_q[0]) + 2'(acc_q[0]) + 2'(inc_c_q);
	assign main_sum = 2'(main_q[0]) + 2'(inc_sum[0]) + 2'(main_c_q);
	always_comb begin
		msum = 3'(CARRIER_BIT0 & inc_sum[0]);
		for (int k = 1; k < MB; k++) begin
			msum = msum + 3'(pvenv_pkg::CARRIER_MULT[k] & hist_q[k-1]);
		end
	end
	assign sec_sum = 4'(second_q[0]) + 4'(det_sr_q[0]) + 4'(msum) + 4'(sec_c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= OS_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			main_q     <= '0;
			second_q   <= '0;
			pitch_sr_q <= '0;
			det_sr_q   <= '0;
			mplier_q   <= '0;
			mcand_q    <= '0;
			acc_q      <= '0;
			inc_c_q    <= 1'b0;
			main_c_q   <= 1'b0;
			sec_c_q    <= '0;
			hist_q     <= '0;
			sample_q   <= '0;
		end else begin
			// one-cycle pulse after the last phase bit
			done_q <= (state_q == OS_ADD) && (cnt_q == CNT_BITS'(PB - 1));
			unique case (state_q)
				OS_IDLE: begin
					if (ctl.clear) begin
						main_q   <= '0;
						second_q <= '0;
					end
					if (ctl.start) begin
						sample_q   <= sample_next;
						mplier_q   <= voice.depth;
						mcand_q    <= ACC_BITS'(voice.cosine);
						acc_q      <= '0;
						pitch_sr_q <= voice.pitch;
						det_sr_q   <= cfg.second_detune;
						cnt_q      <= '0;
						state_q    <= OS_MUL;
					end
				end
				OS_MUL: begin
					mplier_q <= mplier_q >> 1;
					mcand_q  <= mcand_q <<< 1;
					if (cnt_q == CNT_BITS'(pvenv_pkg::DEPTH_BITS - 1)) begin
						// keep only the vibrato offset, sign in the upper bits
						acc_q    <= acc_mul >>> VIB_SHIFT;
						inc_c_q  <= 1'b0;
						main_c_q <= 1'b0;
						sec_c_q  <= '0;
						hist_q   <= '0;
						cnt_q    <= '0;
						state_q  <= OS_ADD;
					end else begin
						acc_q <= acc_mul;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				OS_ADD: begin
					acc_q      <= acc_q >>> 1;
					pitch_sr_q <= pitch_sr_q >> 1;
					det_sr_q   <= det_sr_q >> 1;
					inc_c_q    <= inc_sum[1];
					main_c_q   <= main_sum[1];
					sec_c_q    <= sec_sum[3:1];
					main_q     <= {main_sum[0], main_q[PB-1:1]};
					second_q   <= {sec_sum[0], second_q[PB-1:1]};
					hist_q     <= {hist_q[MB-3:0], inc_sum[0]};
					cnt_q      <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(PB - 1)) begin
						state_q <= OS_IDLE;
					end
				end
				default: state_q <= OS_IDLE;
			endcase
		end
	end

	assign stat.busy = (state_q != OS_IDLE);
	assign stat.done = done_q;
	assign sample    = sample_q;

endmodule

// File: rtl/pulse_voice_with_envelope_top.sv
// Note on, note off and envelope tick complete in the accept cycle; the next word can be taken
// in the cycle after.
// A sample tick runs an 8-bit shift-add multiply for the vibrato offset, then a bit-serial add
// over the 18 phase bits; no word is taken until its sample is loaded into the output register.
// The output register holds a finished word while further commands are accepted.
// arst_n (asynchronous, active low) clears voice state and restores register defaults.
module pulse_voice_with_envelope_top (
	input  logic                            clk,
	input  logic                            arst_n,
	pvenv_cmd_if.sink                       cmd,
	pvenv_smp_if.source                     smp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pvenv_pkg::ADDR_BITS-1:0] paddr,
	input  logic [pvenv_pkg::DATA_BITS-1:0] pwdata,
	output logic [pvenv_pkg::DATA_BITS-1:0] prdata,
	output logic                            pready
);

	typedef enum logic [1:0] {
		TS_IDLE,
		TS_RUN,
		TS_HOLD
	} tstate_t;

	tstate_t                                   state_q;
	logic                                      smp_valid_q;
	logic signed [pvenv_pkg::SAMPLE_BITS-1:0]  smp_data_q;

	pvenv_pkg::cfg_t                           cfg;
	pvenv_pkg::env_cmd_t                       env_cmd;
	pvenv_pkg::voice_t                         voice;
	pvenv_pkg::osc_ctl_t                       osc_ctl;
	pvenv_pkg::osc_stat_t                      osc_stat;
	logic signed [pvenv_pkg::SAMPLE_BITS-1:0]  osc_sample;
	logic                                      cmd_acc;
	logic                                      out_free;
	logic                                      out_load;

	pvenv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pvenv_env u_env (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (env_cmd),
		.voice  (voice)
	);

	pvenv_osc u_osc (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.voice  (voice),
		.ctl    (osc_ctl),
		.stat   (osc_stat),
		.sample (osc_sample)
	);

	// command decode
	assign cmd.ready        = (state_q == TS_IDLE);
	assign cmd_acc          = cmd.valid & cmd.ready;
	assign env_cmd.note_on  = cmd_acc && (cmd.opcode == pvenv_pkg::OP_NOTE_ON);
	assign env_cmd.note_off = cmd_acc && (cmd.opcode == pvenv_pkg::OP_NOTE_OFF);
	assign env_cmd.tick     = cmd_acc && (cmd.opcode == pvenv_pkg::OP_ENV_TICK);
	assign env_cmd.note     = cmd.note;
	assign osc_ctl.clear    = env_cmd.note_on;
	assign osc_ctl.start    = cmd_acc && (cmd.opcode == pvenv_pkg::OP_SAMPLE);

	// output register
	assign out_free   = !smp_valid_q || smp.ready;
	assign out_load   = out_free &&
		(((state_q == TS_RUN) && osc_stat.done) || (state_q == TS_HOLD));
	assign smp.valid  = smp_valid_q;
	assign smp.sample = smp_data_q;

	// sequencer and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TS_IDLE;
			smp_valid_q <= 1'b0;
			smp_data_q  <= '0;
		end else begin
			if (out_load) begin
				smp_valid_q <= 1'b1;
				smp_data_q  <= osc_sample;
			end else if (smp.ready) begin
				smp_valid_q <= 1'b0;
			end
			unique case (state_q)
				TS_IDLE: begin
					if (osc_ctl.start) state_q <= TS_RUN;
				end
				TS_RUN: begin
					if (osc_stat.done) begin
						if (out_free) state_q <= TS_IDLE;
						else          state_q <= TS_HOLD;
					end
				end
				TS_HOLD: begin
					if (out_free) state_q <= TS_IDLE;
				end
				default: state_q <= TS_IDLE;
			endcase
		end
	end

	// oscillator finishes only while a sample tick is pending
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		osc_stat.done |-> (state_q == TS_RUN))
		else $error("oscillator done outside a sample tick");

	// an accepted sample tick starts the serial pass
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		osc_ctl.start |=> osc_stat.busy)
		else $error("sample tick did not start the oscillator");

	// waiting to hand over only while the output register is full
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TS_HOLD) |-> smp_valid_q)
		else $error("holding a word with an empty output register");

endmodule

// File: tb/sv/tb_pulse_voice_with_envelope_top.sv
`timescale 1ns / 100ps

module tb_pulse_voice_with_envelope_top;

	// envelope stage codes
	localparam logic [2:0] ENV_IDLE    = 3'd0;
	localparam logic [2:0] ENV_ATTACK  = 3'd1;
	localparam logic [2:0] ENV_DECAY   = 3'd2;
	localparam logic [2:0] ENV_SUSTAIN = 3'd3;
	localparam logic [2:0] ENV_RELEASE = 3'd4;

	// 2^(r/12) with 24 fraction bits
	localparam longint unsigned SEMITONE [12] = '{
		64'd16777216, 64'd17774841, 64'd18831788, 64'd19951585,
		64'd21137968, 64'd22394897, 64'd23726566, 64'd25137421,
		64'd26632170, 64'd28215802, 64'd29893600, 64'd31671166
	};

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_WORDS   = 100;
	localparam int SETTLE_CYCLES = 32;

	// voice predictor and queue of samples still owed by the block
	class voice_sample_board;
		logic [pvenv_pkg::LEVEL_BITS-1:0]      sustain   = 12'd2048;
		logic [pvenv_pkg::SHIFT_BITS-1:0]      decay_sh  = 4'd4;
		logic [pvenv_pkg::SHIFT_BITS-1:0]      rel_sh    = 4'd4;
		logic [pvenv_pkg::SHIFT_BITS-1:0]      speed_sh  = 4'd6;
		logic [pvenv_pkg::SHIFT_BITS-1:0]      attack_sh = 4'd0;
		logic [pvenv_pkg::DEPTH_BITS-1:0]      depth_max = 8'd0;
		logic                                  duty      = 1'b0;
		logic [pvenv_pkg::PHASE_BITS-1:0]      detune    = '0;

		logic [2:0]                            stage  = ENV_IDLE;
		logic [pvenv_pkg::LEVEL_BITS-1:0]      level  = '0;
		logic [pvenv_pkg::PHASE_BITS-1:0]      step   = '0;
		logic signed [pvenv_pkg::VIB_BITS-1:0] sine   = '0;
		logic signed [pvenv_pkg::VIB_BITS-1:0] cosine = '0;
		logic [pvenv_pkg::DEPTH_BITS-1:0]      depth  = '0;
		logic [pvenv_pkg::PHASE_BITS-1:0]      ph_a   = '0;
		logic [pvenv_pkg::PHASE_BITS-1:0]      ph_b   = '0;

		logic signed [pvenv_pkg::SAMPLE_BITS-1:0] samples_due [$];
		int unsigned bad_count = 0;

		function int unsigned ceil_shift(int unsigned v, int unsigned s);
			return (v + (32'd1 << s) - 32'd1) >> s;
		endfunction

		function int pending();
			return samples_due.size();
		endfunction

		function void set_register(pvenv_pkg::reg_idx_t idx,
				logic [pvenv_pkg::DATA_BITS-1:0] v);
			case (idx)
				pvenv_pkg::REG_SUSTAIN:   sustain   = v[pvenv_pkg::LEVEL_BITS-1:0];
				pvenv_pkg::REG_DECAY:     decay_sh  = v[pvenv_pkg::SHIFT_BITS-1:0];
				pvenv_pkg::REG_RELEASE:   rel_sh    = v[pvenv_pkg::SHIFT_BITS-1:0];
				pvenv_pkg::REG_VIB_SPEED: speed_sh  = v[pvenv_pkg::SHIFT_BITS-1:0];
				pvenv_pkg::REG_VIB_ATTK:  attack_sh = v[pvenv_pkg::SHIFT_BITS-1:0];
				pvenv_pkg::REG_VIB_DEPTH: depth_max = v[pvenv_pkg::DEPTH_BITS-1:0];
				pvenv_pkg::REG_DUTY:      duty      = v[0];
				pvenv_pkg::REG_DETUNE:    detune    = v[pvenv_pkg::PHASE_BITS-1:0];
			endcase
		endfunction

		// advance the voice by one accepted command word
		function void take_command(pvenv_pkg::op_t op, logic [pvenv_pkg::NOTE_BITS-1:0] nt);
			int ee;
			int sh;
			longint unsigned num;
			int vib;
			int total;
			logic [31:0] inc;
			logic hi_a;
			logic hi_b;
			case (op)
				pvenv_pkg::OP_NOTE_ON: begin
					// equal-temperament step, truncated
					ee = int'(nt) - 69 + 12 * pvenv_pkg::OCTAVE_SHIFT + 12 * 16;
					if (ee < 0) ee = 0;
					sh = pvenv_pkg::PHASE_BITS + ee / 12 - 16;
					num = 64'd440 * SEMITONE[ee % 12];
					if (sh >= 0) num = num << sh;
					else num = num >> (-sh);
					step = pvenv_pkg::PHASE_BITS'(num / (longint'(pvenv_pkg::AUDIO_RATE) << 24));
					stage = ENV_DECAY;
					level = pvenv_pkg::LEVEL_FULL;
					sine = '0;
					cosine = pvenv_pkg::COS_START;
					depth = '0;
					ph_a = '0;
					ph_b = '0;
				end
				pvenv_pkg::OP_NOTE_OFF: stage = ENV_RELEASE;
				pvenv_pkg::OP_ENV_TICK: begin
					// vibrato rotation, new cosine feeds the sine
					cosine = cosine - (sine >>> speed_sh);
					sine = sine + (cosine >>> speed_sh);
					case (stage)
						ENV_ATTACK: begin
							level = pvenv_pkg::LEVEL_FULL;
							stage = ENV_DECAY;
						end
						ENV_DECAY: begin
							if (level > sustain)
								level = level - pvenv_pkg::LEVEL_BITS'(
									ceil_shift(level - sustain, decay_sh));
							if (level <= sustain) begin
								level = sustain;
								stage = ENV_SUSTAIN;
							end
							if (attack_sh != 0) begin
								if (depth_max >= depth)
									depth = depth + pvenv_pkg::DEPTH_BITS'(
										ceil_shift(depth_max - depth, attack_sh));
								else
									depth = depth - ((depth - depth_max) >> attack_sh);
							end
						end
						ENV_SUSTAIN: level = sustain;
						ENV_RELEASE: begin
							level = level - pvenv_pkg::LEVEL_BITS'(ceil_shift(level, rel_sh));
							if (level == 0) stage = ENV_IDLE;
						end
						default: ;
					endcase
				end
				default: begin
					// two pulse waves at +/-level, then phase advance
					hi_a = duty ? (&ph_a[pvenv_pkg::PHASE_BITS-1 -: 2])
						: ph_a[pvenv_pkg::PHASE_BITS-1];
					hi_b = duty ? (&ph_b[pvenv_pkg::PHASE_BITS-1 -: 2])
						: ph_b[pvenv_pkg::PHASE_BITS-1];
					total = (hi_a ? int'(level) : -int'(level))
						+ (hi_b ? int'(level) : -int'(level));
					samples_due.push_back(pvenv_pkg::SAMPLE_BITS'(total));
					vib = (int'(depth) * int'(cosine)) >>> 10;
					inc = step + vib;
					ph_a = ph_a + inc;
					ph_b = ph_b + inc * pvenv_pkg::CARRIER_MULT + detune;
				end
			endcase
		endfunction

		function void check_sample(logic signed [pvenv_pkg::SAMPLE_BITS-1:0] got);
			logic signed [pvenv_pkg::SAMPLE_BITS-1:0] want;
			if (samples_due.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: sample %0d with none expected", $realtime, got);
				return;
			end
			want = samples_due.pop_front();
			if (got !== want) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: sample mismatch, expected %0d got %0d", $realtime, want, got);
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pvenv_pkg::ADDR_BITS-1:0] paddr;
	logic [pvenv_pkg::DATA_BITS-1:0] pwdata;
	logic [pvenv_pkg::DATA_BITS-1:0] prdata;
	logic                            pready;
	bit                              steady;

	voice_sample_board sb;

	pvenv_cmd_if cmd_if ();
	pvenv_smp_if smp_if ();

	pulse_voice_with_envelope_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_if),
		.smp     (smp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// sample sink with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			smp_if.ready <= 1'b0;
		end else begin
			if (smp_if.valid && smp_if.ready) sb.check_sample(smp_if.sample);
			smp_if.ready <= steady || ($urandom_range(99) >= 38);
		end
	end

	// one command word, with random idle cycles ahead of it
	task automatic send_word(pvenv_pkg::op_t op, logic [pvenv_pkg::NOTE_BITS-1:0] nt);
		while (!steady && $urandom_range(99) < 38) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.opcode <= op;
		cmd_if.note <= nt;
		do @(posedge clk); while (!cmd_if.ready);
		sb.take_command(op, nt);
	endtask

	// hold off until every owed sample is out and the block is quiet
	task automatic drain();
		cmd_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(pvenv_pkg::reg_idx_t idx, logic [pvenv_pkg::DATA_BITS-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic write_all(pvenv_pkg::cfg_t c);
		apb_write(pvenv_pkg::REG_SUSTAIN,   pvenv_pkg::DATA_BITS'(c.sustain_level));
		apb_write(pvenv_pkg::REG_DECAY,     pvenv_pkg::DATA_BITS'(c.decay_shift));
		apb_write(pvenv_pkg::REG_RELEASE,   pvenv_pkg::DATA_BITS'(c.release_shift));
		apb_write(pvenv_pkg::REG_VIB_SPEED, pvenv_pkg::DATA_BITS'(c.vib_speed_shift));
		apb_write(pvenv_pkg::REG_VIB_ATTK,  pvenv_pkg::DATA_BITS'(c.vib_attack_shift));
		apb_write(pvenv_pkg::REG_VIB_DEPTH, pvenv_pkg::DATA_BITS'(c.vib_depth_max));
		apb_write(pvenv_pkg::REG_DUTY,      pvenv_pkg::DATA_BITS'(c.duty_select));
		apb_write(pvenv_pkg::REG_DETUNE,    pvenv_pkg::DATA_BITS'(c.second_detune));
	endtask

	initial begin
		pvenv_pkg::cfg_t c;
		int pick;
		sb = new;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_if.valid <= 1'b0;
		cmd_if.opcode <= pvenv_pkg::OP_NOTE_ON;
		cmd_if.note <= '0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle voice, note off while idle, note extremes
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);
		send_word(pvenv_pkg::OP_NOTE_OFF, 7'd127);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd85);
		send_word(pvenv_pkg::OP_NOTE_ON, 7'd127);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd127);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd42);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);
		send_word(pvenv_pkg::OP_NOTE_ON, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);

		// slow decay, fast vibrato ramp, quarter duty, full detune
		drain();
		apb_write(pvenv_pkg::REG_DECAY, 32'd15);
		apb_write(pvenv_pkg::REG_VIB_ATTK, 32'd1);
		apb_write(pvenv_pkg::REG_VIB_DEPTH, 32'd255);
		apb_write(pvenv_pkg::REG_VIB_SPEED, 32'd1);
		apb_write(pvenv_pkg::REG_DUTY, 32'd1);
		apb_write(pvenv_pkg::REG_DETUNE, 32'd262143);
		send_word(pvenv_pkg::OP_NOTE_ON, 7'd69);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd0);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);

		// sustain raised above the level while still in decay
		drain();
		apb_write(pvenv_pkg::REG_SUSTAIN, 32'd4095);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);

		// release with no shift drops to zero in one tick
		drain();
		apb_write(pvenv_pkg::REG_RELEASE, 32'd0);
		send_word(pvenv_pkg::OP_NOTE_OFF, 7'd0);
		send_word(pvenv_pkg::OP_ENV_TICK, 7'd0);
		send_word(pvenv_pkg::OP_SAMPLE, 7'd0);

		// random phases: note sequences under several settings
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			if (ph == 1) begin
				c = '0;
			end else if (ph == 2) begin
				c = '1;
			end else begin
				c.sustain_level = pvenv_pkg::LEVEL_BITS'($urandom_range(4095));
				c.decay_shift = pvenv_pkg::SHIFT_BITS'($urandom_range(15));
				c.release_shift = pvenv_pkg::SHIFT_BITS'($urandom_range(15));
				c.vib_speed_shift = pvenv_pkg::SHIFT_BITS'($urandom_range(15));
				c.vib_attack_shift = pvenv_pkg::SHIFT_BITS'($urandom_range(15));
				c.vib_depth_max = pvenv_pkg::DEPTH_BITS'($urandom_range(255));
				c.duty_select = 1'($urandom_range(1));
				c.second_detune = pvenv_pkg::PHASE_BITS'($urandom_range(262143));
			end
			write_all(c);
			steady = (ph == 2);
			send_word(pvenv_pkg::OP_NOTE_ON, pvenv_pkg::NOTE_BITS'($urandom_range(127)));
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (ph == 3 && i == PHASE_WORDS / 2) begin
					cmd_if.valid <= 1'b0;
					while (sb.pending() != 0) @(posedge clk);
				end
				pick = $urandom_range(99);
				if (pick < 4)
					send_word(pvenv_pkg::OP_NOTE_ON,
						pvenv_pkg::NOTE_BITS'($urandom_range(127)));
				else if (pick < 10)
					send_word(pvenv_pkg::OP_NOTE_OFF,
						pvenv_pkg::NOTE_BITS'($urandom_range(127)));
				else if (pick < 50)
					send_word(pvenv_pkg::OP_ENV_TICK,
						pvenv_pkg::NOTE_BITS'($urandom_range(127)));
				else
					send_word(pvenv_pkg::OP_SAMPLE,
						pvenv_pkg::NOTE_BITS'($urandom_range(127)));
			end
		end
		steady = 1'b0;

		drain();
		if (sb.bad_count == 0 && sb.pending() == 0) begin
			$display("** pulse_voice_with_envelope_top: PASSED **");
		end else begin
			$display("** pulse_voice_with_envelope_top: FAILED **");
		end
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("** pulse_voice_with_envelope_top: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
rtl/pvenv_pkg.sv
rtl/pvenv_cmd_if.sv
rtl/pvenv_smp_if.sv
rtl/pvenv_regs.sv
rtl/pvenv_env.sv
rtl/pvenv_osc.sv
rtl/pulse_voice_with_envelope_top.sv
tb/sv/tb_pulse_voice_with_envelope_top.sv
